// ===== sv/tto_pkg.sv =====
// ----------------------------------------------------------------------------
// tto_pkg: shared constants and width helpers
// Fixed port widths, pipeline depth and the width rules of the contact test.
// ----------------------------------------------------------------------------
`default_nettype none

package tto_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int VERTEX_WIDTH    = 48;
  localparam int MARGIN_WIDTH    = 16;
  localparam int NUM_AXES        = 17;
  // Vertices other than the origin vertex (A0), which always projects to 0
  localparam int NUM_VERT        = 5;
  // Register stages from accepted transaction to result strobe
  localparam int LATENCY         = 10;

  // Relative vertex coordinate
  function automatic int vert_width(int cw);
    return cw + 1;
  endfunction

  // Edge vector component
  function automatic int edge_width(int cw);
    return cw + 2;
  endfunction

  // Face normal / edge-edge cross product component
  function automatic int norm_width(int cw);
    return 2 * edge_width(cw) + 1;
  endfunction

  // Common axis width (in-plane edge normals are the widest)
  function automatic int axis_width(int cw);
    return 3 * edge_width(cw) + 2;
  endfunction

  // Exact projection of a vertex onto an axis
  function automatic int proj_width(int cw);
    return axis_width(cw) + vert_width(cw) + 2;
  endfunction

endpackage

`default_nettype wire

// ===== sv/triangle_triangle_overlap.sv =====
// ----------------------------------------------------------------------------
// triangle_triangle_overlap: 3D triangle pair contact test, 17 separating axes
// Fully pipelined exact fixed-point test; one pair per clock.
// ----------------------------------------------------------------------------
// Pulse start with a triangle pair on the six vertex ports; busy is always
// low, so a new transaction may be issued in every cycle. Each pair produces
// exactly one result: done is high for one cycle, and contact is loaded with
// it and holds until the next result. The receiver cannot hold results off,
// so it must take every done pulse. The result path is set by the pipeline:
// four stages build the axes (relative vertices and edges, cross products,
// split partial products of the in-plane normals, their recombination),
// three stages project every vertex onto every axis with the wide axis cut
// into two halves per multiplier, two stages compare the projection
// intervals, and one stage ANDs the 17 axis results. Write the separation
// margin only while no transaction is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_triangle_overlap #(
  parameter int COORD_WIDTH = tto_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [tto_pkg::VERTEX_WIDTH-1:0] tri_a_vertex0,
  input  wire logic [tto_pkg::VERTEX_WIDTH-1:0] tri_a_vertex1,
  input  wire logic [tto_pkg::VERTEX_WIDTH-1:0] tri_a_vertex2,
  input  wire logic [tto_pkg::VERTEX_WIDTH-1:0] tri_b_vertex0,
  input  wire logic [tto_pkg::VERTEX_WIDTH-1:0] tri_b_vertex1,
  input  wire logic [tto_pkg::VERTEX_WIDTH-1:0] tri_b_vertex2,
  input  wire logic                              cfg_write,
  input  wire logic [tto_pkg::MARGIN_WIDTH-1:0] cfg_data,
  output logic                                   done,
  output logic                                   contact
);

  localparam int VW  = tto_pkg::vert_width(COORD_WIDTH);
  localparam int AXW = tto_pkg::axis_width(COORD_WIDTH);
  localparam int PW  = tto_pkg::proj_width(COORD_WIDTH);
  localparam int LAT = tto_pkg::LATENCY;
  localparam int NA  = tto_pkg::NUM_AXES;
  localparam int NV  = tto_pkg::NUM_VERT;

  // Pipeline never stalls: accept a transaction every cycle
  assign busy = 1'b0;

  // Separation margin register
  logic [tto_pkg::MARGIN_WIDTH-1:0] margin;

  always_ff @(posedge clk) begin
    if (rst) begin
      margin <= '0;
    end else if (cfg_write) begin
      margin <= cfg_data;
    end
  end

  // Valid bits travel alongside the data path
  logic [LAT-1:0] valid_pipe;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_pipe <= '0;
    end else begin
      valid_pipe <= {valid_pipe[LAT-2:0], start && !busy};
    end
  end

  assign done = valid_pipe[LAT-1];

  // Axis generation
  logic [tto_pkg::VERTEX_WIDTH-1:0] vtx [6];
  logic signed [VW-1:0]  vert [NV][3];
  logic signed [AXW-1:0] axis [NA][3];

  always_comb begin
    vtx[0] = tri_a_vertex0;
    vtx[1] = tri_a_vertex1;
    vtx[2] = tri_a_vertex2;
    vtx[3] = tri_b_vertex0;
    vtx[4] = tri_b_vertex1;
    vtx[5] = tri_b_vertex2;
  end

  tto_axes #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_axes (
    .clk  (clk),
    .vtx  (vtx),
    .vert (vert),
    .axis (axis)
  );

  // One projection unit and one interval check per axis
  logic [NA-1:0] touch;

  for (genvar a = 0; a < NA; a++) begin : g_axis
    logic signed [PW-1:0] proj [NV];

    tto_project #(
      .COORD_WIDTH(COORD_WIDTH)
    ) u_project (
      .clk  (clk),
      .axis (axis[a]),
      .vert (vert),
      .proj (proj)
    );

    tto_gap #(
      .COORD_WIDTH(COORD_WIDTH)
    ) u_gap (
      .clk    (clk),
      .proj   (proj),
      .margin (margin),
      .touch  (touch[a])
    );
  end

  // Contact holds only when no axis separates; load it on the next-to-last valid bit so it updates with done
  always_ff @(posedge clk) begin
    if (valid_pipe[LAT-2]) begin
      contact <= &touch;
    end
  end

`ifndef SYNTH
  a_done_from_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result strobe without a matching transaction");

  a_identical_touch: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && tri_a_vertex0 == tri_b_vertex0 && tri_a_vertex1 == tri_b_vertex1
     && tri_a_vertex2 == tri_b_vertex2) |-> ##LAT (done && contact))
    else $error("identical triangles reported as separated");

  a_point_on_vertex: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && tri_b_vertex0 == tri_a_vertex0 && tri_b_vertex1 == tri_a_vertex0
     && tri_b_vertex2 == tri_a_vertex0) |-> ##LAT (done && contact))
    else $error("point at a vertex of A reported as separated");
`endif

endmodule

`default_nettype wire

// ===== sv/tto_axes.sv =====
// ----------------------------------------------------------------------------
// tto_axes: relative vertices and the 17 candidate axes
// Four stages: relative coordinates and edges, cross products, split partial
// products of the in-plane normals, and their recombination.
// ----------------------------------------------------------------------------
`default_nettype none

module tto_axes #(
  parameter int COORD_WIDTH = tto_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic [tto_pkg::VERTEX_WIDTH-1:0] vtx [6],
  output logic signed [tto_pkg::vert_width(COORD_WIDTH)-1:0]
                                                 vert [tto_pkg::NUM_VERT][3],
  output logic signed [tto_pkg::axis_width(COORD_WIDTH)-1:0]
                                                 axis [tto_pkg::NUM_AXES][3]
);

  localparam int VW  = tto_pkg::vert_width(COORD_WIDTH);
  localparam int EW  = tto_pkg::edge_width(COORD_WIDTH);
  localparam int NW  = tto_pkg::norm_width(COORD_WIDTH);
  localparam int AXW = tto_pkg::axis_width(COORD_WIDTH);
  localparam int NL  = EW;
  localparam int NH  = NW - NL;
  localparam int PLW = EW + NL + 1;
  localparam int PHW = EW + NH;
  localparam int NV  = tto_pkg::NUM_VERT;

  // stage 1
  logic signed [COORD_WIDTH-1:0] crd [6][3];
  logic signed [VW-1:0] rel [6][3];
  logic signed [EW-1:0] e_next [3][3];
  logic signed [EW-1:0] f_next [3][3];
  logic signed [VW-1:0] s1_v [NV][3];
  logic signed [EW-1:0] s1_e [3][3];
  logic signed [EW-1:0] s1_f [3][3];

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      for (int k = 0; k < 3; k++) begin
        crd[i][k] = $signed(vtx[i][k*COORD_WIDTH +: COORD_WIDTH]);
        rel[i][k] = VW'(crd[i][k]) - VW'(crd[0][k]);
      end
    end
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        e_next[i][k] = EW'(rel[(i+1)%3][k]) - EW'(rel[i][k]);
        f_next[i][k] = EW'(rel[3+(i+1)%3][k]) - EW'(rel[3+i][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NV; i++) begin
      for (int k = 0; k < 3; k++) begin
        s1_v[i][k] <= rel[i+1][k];
      end
    end
    s1_e <= e_next;
    s1_f <= f_next;
  end

  // stage 2: face normals and edge-edge axes
  // axis order: 0 normal of A, 1 normal of B, 2..10 edge pairs
  logic signed [NW-1:0] cr_next [11][3];
  logic signed [VW-1:0] s2_v [NV][3];
  logic signed [EW-1:0] s2_e [3][3];
  logic signed [EW-1:0] s2_f [3][3];
  logic signed [NW-1:0] s2_ax [11][3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cr_next[0][k] = NW'(s1_e[0][(k+1)%3] * s1_e[1][(k+2)%3])
                    - NW'(s1_e[0][(k+2)%3] * s1_e[1][(k+1)%3]);
      cr_next[1][k] = NW'(s1_f[0][(k+1)%3] * s1_f[1][(k+2)%3])
                    - NW'(s1_f[0][(k+2)%3] * s1_f[1][(k+1)%3]);
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          cr_next[2+3*i+j][k] = NW'(s1_e[i][(k+1)%3] * s1_f[j][(k+2)%3])
                              - NW'(s1_e[i][(k+2)%3] * s1_f[j][(k+1)%3]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    s2_v  <= s1_v;
    s2_e  <= s1_e;
    s2_f  <= s1_f;
    s2_ax <= cr_next;
  end

  // stage 3: partial products of edge x normal, normal split in two halves
  // in-plane order: e0, f0, e1, f1, e2, f2
  logic signed [EW-1:0] ipe [6][3];
  logic signed [NW-1:0] ipn [6][3];
  logic signed [PLW-1:0] plo_next [6][3][2];
  logic signed [PHW-1:0] phi_next [6][3][2];
  logic signed [PLW-1:0] s3_plo [6][3][2];
  logic signed [PHW-1:0] s3_phi [6][3][2];
  logic signed [VW-1:0] s3_v [NV][3];
  logic signed [NW-1:0] s3_ax [11][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ipe[2*i]   = s2_e[i];
      ipn[2*i]   = s2_ax[0];
      ipe[2*i+1] = s2_f[i];
      ipn[2*i+1] = s2_ax[1];
    end
    for (int a = 0; a < 6; a++) begin
      for (int k = 0; k < 3; k++) begin
        plo_next[a][k][0] = ipe[a][(k+1)%3] * $signed({1'b0, ipn[a][(k+2)%3][NL-1:0]});
        phi_next[a][k][0] = ipe[a][(k+1)%3] * $signed(ipn[a][(k+2)%3][NW-1:NL]);
        plo_next[a][k][1] = ipe[a][(k+2)%3] * $signed({1'b0, ipn[a][(k+1)%3][NL-1:0]});
        phi_next[a][k][1] = ipe[a][(k+2)%3] * $signed(ipn[a][(k+1)%3][NW-1:NL]);
      end
    end
  end

  always_ff @(posedge clk) begin
    s3_plo <= plo_next;
    s3_phi <= phi_next;
    s3_v   <= s2_v;
    s3_ax  <= s2_ax;
  end

  // stage 4: recombine halves and widen all axes to one format
  logic signed [AXW-1:0] term [6][3][2];
  logic signed [AXW-1:0] axis_next [tto_pkg::NUM_AXES][3];

  always_comb begin
    for (int a = 0; a < 11; a++) begin
      for (int k = 0; k < 3; k++) begin
        axis_next[a][k] = AXW'(s3_ax[a][k]);
      end
    end
    for (int a = 0; a < 6; a++) begin
      for (int k = 0; k < 3; k++) begin
        for (int t = 0; t < 2; t++) begin
          term[a][k][t] = (AXW'(s3_phi[a][k][t]) <<< NL) + AXW'(s3_plo[a][k][t]);
        end
        axis_next[11+a][k] = term[a][k][0] - term[a][k][1];
      end
    end
  end

  logic signed [AXW-1:0] s4_ax [tto_pkg::NUM_AXES][3];

  always_ff @(posedge clk) begin
    vert  <= s3_v;
    s4_ax <= axis_next;
  end

  // hand each projection unit all three components of its axis
  always_comb begin
    for (int a = 0; a < tto_pkg::NUM_AXES; a++) begin
      for (int k = 0; k < 3; k++) begin
        axis[a][k] = s4_ax[a][k];
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/tto_project.sv =====
// ----------------------------------------------------------------------------
// tto_project: exact projection of five vertices onto one axis
// Split partial products, recombine per component, then the three-term sum.
// ----------------------------------------------------------------------------
`default_nettype none

module tto_project #(
  parameter int COORD_WIDTH = tto_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                                          clk,
  input  wire logic signed [tto_pkg::axis_width(COORD_WIDTH)-1:0] axis [3],
  input  wire logic signed [tto_pkg::vert_width(COORD_WIDTH)-1:0]
                                                   vert [tto_pkg::NUM_VERT][3],
  output logic signed [tto_pkg::proj_width(COORD_WIDTH)-1:0]
                                                   proj [tto_pkg::NUM_VERT]
);

  localparam int VW  = tto_pkg::vert_width(COORD_WIDTH);
  localparam int AXW = tto_pkg::axis_width(COORD_WIDTH);
  localparam int PW  = tto_pkg::proj_width(COORD_WIDTH);
  localparam int AL  = AXW / 2;
  localparam int AH  = AXW - AL;
  localparam int NV  = tto_pkg::NUM_VERT;

  logic signed [VW+AL:0]   plo_next [NV][3];
  logic signed [VW+AH-1:0] phi_next [NV][3];
  logic signed [VW+AL:0]   plo [NV][3];
  logic signed [VW+AH-1:0] phi [NV][3];
  logic signed [PW-1:0]    prod_next [NV][3];
  logic signed [PW-1:0]    prod [NV][3];

  always_comb begin
    for (int i = 0; i < NV; i++) begin
      for (int k = 0; k < 3; k++) begin
        plo_next[i][k] = vert[i][k] * $signed({1'b0, axis[k][AL-1:0]});
        phi_next[i][k] = vert[i][k] * $signed(axis[k][AXW-1:AL]);
      end
    end
  end

  always_ff @(posedge clk) begin
    plo <= plo_next;
    phi <= phi_next;
  end

  always_comb begin
    for (int i = 0; i < NV; i++) begin
      for (int k = 0; k < 3; k++) begin
        prod_next[i][k] = (PW'(phi[i][k]) <<< AL) + PW'(plo[i][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= prod_next;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NV; i++) begin
      proj[i] <= prod[i][0] + prod[i][1] + prod[i][2];
    end
  end

endmodule

`default_nettype wire

// ===== sv/tto_gap.sv =====
// ----------------------------------------------------------------------------
// tto_gap: interval overlap check on one axis
// Min/max of both triangles' projections, then the gap against the margin.
// ----------------------------------------------------------------------------
`default_nettype none

module tto_gap #(
  parameter int COORD_WIDTH = tto_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                                          clk,
  input  wire logic signed [tto_pkg::proj_width(COORD_WIDTH)-1:0]
                                                   proj [tto_pkg::NUM_VERT],
  input  wire logic [tto_pkg::MARGIN_WIDTH-1:0]              margin,
  output logic                                               touch
);

  localparam int PW = tto_pkg::proj_width(COORD_WIDTH);

  logic signed [PW-1:0] mn_a_next, mx_a_next, mn_b_next, mx_b_next;
  logic signed [PW-1:0] mn_a, mx_a, mn_b, mx_b;
  logic signed [PW:0]   gap_ab, gap_ba, lim;

  // triangle A: origin vertex projects to zero
  always_comb begin
    mn_a_next = '0;
    mx_a_next = '0;
    for (int i = 0; i < 2; i++) begin
      if (proj[i] < mn_a_next) mn_a_next = proj[i];
      if (proj[i] > mx_a_next) mx_a_next = proj[i];
    end
    mn_b_next = proj[2];
    mx_b_next = proj[2];
    for (int i = 3; i < 5; i++) begin
      if (proj[i] < mn_b_next) mn_b_next = proj[i];
      if (proj[i] > mx_b_next) mx_b_next = proj[i];
    end
  end

  always_ff @(posedge clk) begin
    mn_a <= mn_a_next;
    mx_a <= mx_a_next;
    mn_b <= mn_b_next;
    mx_b <= mx_b_next;
  end

  always_comb begin
    gap_ab = (PW+1)'(mn_a) - (PW+1)'(mx_b);
    gap_ba = (PW+1)'(mn_b) - (PW+1)'(mx_a);
    lim    = (PW+1)'($signed({1'b0, margin}));
  end

  always_ff @(posedge clk) begin
    touch <= !((gap_ab > lim) || (gap_ba > lim));
  end

endmodule

`default_nettype wire

// ===== tb/triangle_triangle_overlap_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangle_triangle_overlap_checker: contact prediction and result compare
// Watches the command and result channels, computes the contact flag of each
// accepted triangle pair exactly and compares it with the strobed result.
// ----------------------------------------------------------------------------
module triangle_triangle_overlap_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [47:0] tri_a_vertex0,
  input  logic [47:0] tri_a_vertex1,
  input  logic [47:0] tri_a_vertex2,
  input  logic [47:0] tri_b_vertex0,
  input  logic [47:0] tri_b_vertex1,
  input  logic [47:0] tri_b_vertex2,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  input  logic        done,
  input  logic        contact,
  output int          error_count,
  output int          pending_count
);

  typedef logic signed [127:0] wide_t;

  bit          contact_fifo[$];
  logic [15:0] margin;

  function automatic wide_t coord_of(logic [47:0] w, int k);
    logic signed [15:0] c;
    c = w[k*16 +: 16];
    return wide_t'(c);
  endfunction

  function automatic void cross_vec(output wide_t r[3], input wide_t a[3], input wide_t b[3]);
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic wide_t dot_vec(wide_t a[3], wide_t b[3]);
    return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
  endfunction

  // Gap between the A and B intervals beyond the margin separates
  function automatic bit intervals_touch(wide_t p[6], logic [15:0] mg);
    wide_t mn1, mx1, mn2, mx2, m;
    mn1 = p[0]; mx1 = p[0]; mn2 = p[3]; mx2 = p[3];
    m = wide_t'({1'b0, mg});
    for (int i = 1; i < 3; i++) begin
      if (p[i] < mn1) mn1 = p[i];
      if (p[i] > mx1) mx1 = p[i];
      if (p[i+3] < mn2) mn2 = p[i+3];
      if (p[i+3] > mx2) mx2 = p[i+3];
    end
    return !((mn1 - mx2 > m) || (mn2 - mx1 > m));
  endfunction

  function automatic bit axis_touch(wide_t ax[3], wide_t v[6][3], logic [15:0] mg);
    wide_t p[6];
    for (int i = 0; i < 6; i++) p[i] = dot_vec(ax, v[i]);
    return intervals_touch(p, mg);
  endfunction

  // In-plane edge normal: (edge x n).v == n.(v x edge)
  function automatic bit inplane_touch(wide_t ed[3], wide_t n[3], wide_t v[6][3],
                                       logic [15:0] mg);
    wide_t p[6];
    wide_t t[3];
    for (int i = 0; i < 6; i++) begin
      cross_vec(t, v[i], ed);
      p[i] = dot_vec(n, t);
    end
    return intervals_touch(p, mg);
  endfunction

  function automatic bit predict_contact(logic [47:0] w[6], logic [15:0] mg);
    wide_t v[6][3];
    wide_t e[3][3];
    wide_t f[3][3];
    wide_t n1[3];
    wide_t m1[3];
    wide_t ax[3];
    bit    hit;
    hit = 1'b1;
    for (int i = 0; i < 6; i++)
      for (int k = 0; k < 3; k++) v[i][k] = coord_of(w[i], k) - coord_of(w[0], k);
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++) begin
        e[i][k] = v[(i+1)%3][k] - v[i][k];
        f[i][k] = v[3+(i+1)%3][k] - v[3+i][k];
      end
    cross_vec(n1, e[0], e[1]);
    cross_vec(m1, f[0], f[1]);
    hit &= axis_touch(n1, v, mg);
    hit &= axis_touch(m1, v, mg);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        cross_vec(ax, e[i], f[j]);
        hit &= axis_touch(ax, v, mg);
      end
    for (int i = 0; i < 3; i++) begin
      hit &= inplane_touch(e[i], n1, v, mg);
      hit &= inplane_touch(f[i], m1, v, mg);
    end
    return hit;
  endfunction

  assign pending_count = contact_fifo.size();

  always @(posedge clk) begin
    logic [47:0] w[6];
    bit          exp_contact;
    if (rst) begin
      margin <= '0;
      contact_fifo.delete();
      error_count <= 0;
    end else begin
      if (start && !busy) begin
        w[0] = tri_a_vertex0; w[1] = tri_a_vertex1; w[2] = tri_a_vertex2;
        w[3] = tri_b_vertex0; w[4] = tri_b_vertex1; w[5] = tri_b_vertex2;
        contact_fifo.push_back(predict_contact(w, margin));
      end
      if (done) begin
        if (contact_fifo.size() == 0) begin
          $error("unexpected result: contact=%0b", contact);
          error_count <= error_count + 1;
        end else begin
          exp_contact = contact_fifo.pop_front();
          if (contact !== exp_contact) begin
            $error("contact mismatch: expected %0b actual %0b", exp_contact, contact);
            error_count <= error_count + 1;
          end
        end
      end
      if (cfg_write) margin <= cfg_data;
    end
  end

endmodule

// ===== tb/triangle_triangle_overlap_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangle_triangle_overlap_test: testbench top for the triangle contact test
// Drives directed and random triangle pairs under several margins with random
// gaps, and gives the verdict from the checker's error and pending counts.
// ----------------------------------------------------------------------------
module triangle_triangle_overlap_test;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [47:0] tri_a_vertex0 = '0;
  logic [47:0] tri_a_vertex1 = '0;
  logic [47:0] tri_a_vertex2 = '0;
  logic [47:0] tri_b_vertex0 = '0;
  logic [47:0] tri_b_vertex1 = '0;
  logic [47:0] tri_b_vertex2 = '0;
  logic        cfg_write = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        done;
  logic        contact;
  int          error_count;
  int          pending_count;
  int          idle_cycles;
  bit          steady_run;

  always #5 clk = ~clk;

  triangle_triangle_overlap u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .tri_a_vertex0(tri_a_vertex0), .tri_a_vertex1(tri_a_vertex1),
    .tri_a_vertex2(tri_a_vertex2), .tri_b_vertex0(tri_b_vertex0),
    .tri_b_vertex1(tri_b_vertex1), .tri_b_vertex2(tri_b_vertex2),
    .cfg_write(cfg_write), .cfg_data(cfg_data), .done(done), .contact(contact)
  );

  triangle_triangle_overlap_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .tri_a_vertex0(tri_a_vertex0), .tri_a_vertex1(tri_a_vertex1),
    .tri_a_vertex2(tri_a_vertex2), .tri_b_vertex0(tri_b_vertex0),
    .tri_b_vertex1(tri_b_vertex1), .tri_b_vertex2(tri_b_vertex2),
    .cfg_write(cfg_write), .cfg_data(cfg_data), .done(done), .contact(contact),
    .error_count(error_count), .pending_count(pending_count)
  );

  // Watchdog: count cycles with no transaction and no result
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic logic [47:0] pack_vertex(int x, int y, int z);
    logic [15:0] px, py, pz;
    px = x[15:0]; py = y[15:0]; pz = z[15:0];
    return {pz, py, px};
  endfunction

  function automatic int rand_signed(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // After an optional random gap with start low, hold the pair on the ports with start high until accepted
  task automatic send_pair(logic [47:0] a0, logic [47:0] a1, logic [47:0] a2,
                           logic [47:0] b0, logic [47:0] b1, logic [47:0] b2);
    int gap;
    gap = 0;
    if (!steady_run && $urandom_range(0, 9) >= 7)
      gap = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tri_a_vertex0 <= a0; tri_a_vertex1 <= a1; tri_a_vertex2 <= a2;
    tri_b_vertex0 <= b0; tri_b_vertex1 <= b1; tri_b_vertex2 <= b2;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drop start and drain every outstanding result, then let the pipe empty
  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (tto_pkg::LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_margin(logic [15:0] value);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // One random pair: mostly clustered triangles so both verdicts occur often
  task automatic send_random_pair;
    logic [47:0] w[6];
    int bx, by, bz, ox, oy, oz, spread, mode;
    mode = $urandom_range(0, 9);
    spread = 1 << $urandom_range(0, 12);
    bx = rand_signed(20000); by = rand_signed(20000); bz = rand_signed(20000);
    ox = rand_signed(spread); oy = rand_signed(spread); oz = rand_signed(spread);
    for (int i = 0; i < 6; i++) begin
      if (i < 3)
        w[i] = pack_vertex(bx + rand_signed(spread), by + rand_signed(spread),
                           bz + rand_signed(spread));
      else
        w[i] = pack_vertex(bx + ox + rand_signed(spread), by + oy + rand_signed(spread),
                           bz + oz + rand_signed(spread));
    end
    case (mode)
      0: for (int i = 0; i < 6; i++) w[i] = {$urandom(), 16'($urandom())};
      1: w[3] = w[$urandom_range(0, 2)];                // shared vertex
      2: begin                                          // degenerate A
        w[1] = w[0]; w[2] = w[0];
      end
      3: w[5] = w[4];                                   // B collapses to a segment
      default: ;
    endcase
    send_pair(w[0], w[1], w[2], w[3], w[4], w[5]);
  endtask

  initial begin
    logic [15:0] margins[4];
    logic [47:0] pmax, pmin;
    margins[0] = 16'd0;
    margins[1] = 16'hFFFF;
    margins[2] = 16'($urandom_range(1, 255));
    margins[3] = 16'($urandom());
    steady_run = 1'b0;
    pmax = pack_vertex(32767, 32767, 32767);
    pmin = pack_vertex(-32768, -32768, -32768);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed pairs at the reset margin of zero
    send_pair(pmax, pmin, pack_vertex(32767, -32768, 0), pmin, pmax,
              pack_vertex(-32768, 32767, 0));
    send_pair(pmin, pmin, pmin, pmax, pmax, pmax);      // two points, far apart
    send_pair('0, '0, '0, '0, '0, '0);                  // everything degenerate
    send_pair(pmax, pmax, pmax, pmax, pmax, pmax);
    send_pair(pack_vertex(0, 0, 0), pack_vertex(10, 0, 0), pack_vertex(0, 10, 0),
              pack_vertex(0, 0, 0), pack_vertex(10, 0, 0), pack_vertex(0, 10, 0));
    send_pair(pack_vertex(0, 0, 0), pack_vertex(10, 0, 0), pack_vertex(0, 10, 0),
              pack_vertex(0, 0, 1), pack_vertex(10, 0, 1), pack_vertex(0, 10, 1));
    send_pair(pack_vertex(0, 0, 0), pack_vertex(10, 0, 0), pack_vertex(0, 10, 0),
              pack_vertex(10, 0, 0), pack_vertex(20, 0, 5), pack_vertex(20, 5, -5));
    send_pair(pack_vertex(0, 0, 0), pack_vertex(10, 0, 0), pack_vertex(0, 10, 0),
              pack_vertex(2, 2, -5), pack_vertex(2, 2, 5), pack_vertex(3, 3, 5));
    send_pair(pack_vertex(0, 0, 0), pack_vertex(5, 5, 5), pack_vertex(10, 10, 10),
              pack_vertex(5, 5, 5), pack_vertex(1, 2, 3), pack_vertex(-3, 7, 0));
    send_pair(pack_vertex(-1, -1, -1), pack_vertex(1, 0, 0), pack_vertex(0, 1, 0),
              pack_vertex(-32768, 32767, -32768), pack_vertex(32767, -32768, 32767),
              pack_vertex(0, 0, 32767));
    send_pair(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 48'hFFFF_FFFF_FFFF,
              48'h0000_0000_0001, 48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_margin(margins[ph]);
      // Same touching-at-distance pair under each margin
      send_pair(pack_vertex(0, 0, 0), pack_vertex(4, 0, 0), pack_vertex(0, 4, 0),
                pack_vertex(0, 0, 3), pack_vertex(4, 0, 3), pack_vertex(0, 4, 3));
      for (int n = 0; n < 500; n++) begin
        if (n % 100 == 0) steady_run = ($urandom_range(0, 3) == 0);
        if (n == 250) drain();
        send_random_pair();
      end
      drain();
    end

    if (error_count == 0 && pending_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
